### hw/rtl/osfc_pkg.sv
package osfc_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegFbGains = 3'd0;
  localparam logic [CfgIdxW-1:0] RegObsUpper = 3'd1;
  localparam logic [CfgIdxW-1:0] RegObsLower = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRefPos = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRefAngle = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAngleScale = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPosScale = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTimeStep = 3'd7;

  localparam logic [15:0] TimeStepReset = 16'd655;
  localparam logic signed [63:0] EffortLimit = 64'sd1700 <<< FracBits;
  localparam logic [27:0] Deadband = 28'((64'd1 << FracBits) / 100);
  localparam logic [17:0] FreqBase = 18'd1000;
  localparam logic [17:0] FreqMax = 18'd150000;

  // signed 33x33 multiply, one per cycle
  function automatic logic signed [65:0] smul(logic signed [32:0] a, logic signed [32:0] b);
    smul = 66'(a) * 66'(b);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] x);
    if (x > 66'sh7fffffff) sat32 = 32'sh7fffffff;
    else if (x < -66'sh80000000) sat32 = 32'sh80000000;
    else sat32 = x[31:0];
  endfunction

endpackage

### hw/rtl/observer_state_feedback_controller_top.sv
// result: on an enabled tick the result is registered in StOut once the sequencer has run all its steps;
// on a disabled tick out_valid and the zeroed outputs are registered on the edge that accepts the item
// flow: no new item is taken until the result is taken, since in_ready is high only in StIdle;
// one shared 33x33 multiplier is stepped by a sequencer over 17 products in 18 steps
// reset: rst_ni clears estimates and control, registers to 0, time_step to 655
module observer_state_feedback_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [osfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [osfc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        enable_i,
  input  logic signed [15:0] angle_count_i,
  input  logic signed [31:0] position_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        motor_on_o,
  output logic        direction_o,
  output logic [17:0] step_frequency_o,
  output logic signed [27:0] control_effort_o,
  output logic signed [31:0] est_position_o,
  output logic signed [31:0] est_velocity_o,
  output logic signed [31:0] est_angle_o,
  output logic signed [31:0] est_angle_rate_o
);

  typedef enum logic [1:0] {StIdle, StRun, StOut} state_e;

  state_e state_q;
  logic [4:0] step_q;
  logic [63:0] fb_q, obu_q, obl_q;
  logic signed [31:0] refp_q, refa_q;
  logic [31:0] ascl_q, pscl_q;
  logic [15:0] dt_q;
  logic signed [31:0] est_q [4];
  logic signed [31:0] pred_q [4];
  logic signed [15:0] acnt_q;
  logic signed [31:0] pcnt_q;
  logic signed [65:0] acc_q, prod_q;
  logic signed [31:0] u_q, mx_q, mt_q;
  logic signed [32:0] ex_q, et_q;
  logic signed [32:0] ma, mb;

  function automatic logic signed [32:0] g(logic [63:0] r, int unsigned k);
    g = 33'(signed'(r[16*k +: 16]));
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_q)
      5'd0: begin ma = g(fb_q, 0); mb = 33'(est_q[0]) - 33'(refp_q); end
      5'd1: begin ma = g(fb_q, 1); mb = 33'(est_q[1]); end
      5'd2: begin ma = g(fb_q, 2); mb = 33'(est_q[2]) - 33'(refa_q); end
      5'd3: begin ma = g(fb_q, 3); mb = 33'(est_q[3]); end
      5'd4: begin ma = 33'(acnt_q); mb = {1'b0, ascl_q}; end
      5'd5: begin ma = 33'(pcnt_q); mb = {1'b0, pscl_q}; end
      5'd6: begin ma = {17'd0, dt_q}; mb = 33'(est_q[1]); end
      5'd7: begin ma = {17'd0, dt_q}; mb = 33'(u_q); end
      5'd8: begin ma = {17'd0, dt_q}; mb = 33'(est_q[3]); end
      5'd9: begin ma = g(obu_q, 0); mb = ex_q; end
      5'd10: begin ma = g(obu_q, 1); mb = et_q; end
      5'd11: begin ma = g(obu_q, 2); mb = ex_q; end
      5'd12: begin ma = g(obu_q, 3); mb = et_q; end
      5'd13: begin ma = g(obl_q, 0); mb = ex_q; end
      5'd14: begin ma = g(obl_q, 1); mb = et_q; end
      5'd15: begin ma = g(obl_q, 2); mb = ex_q; end
      5'd16: begin ma = g(obl_q, 3); mb = et_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic signed [65:0] us;
  logic [27:0] mag;
  logic [17:0] fr;
  logic [35:0] frw;
  logic [1:0] row;
  assign us = acc_q >>> 8;
  assign mag = u_q[31] ? 28'(-u_q) : 28'(u_q);
  assign frw = (36'(mag) * 36'd80) >> osfc_pkg::FracBits;
  assign fr = (frw + 36'(osfc_pkg::FreqBase) > 36'(osfc_pkg::FreqMax)) ?
              osfc_pkg::FreqMax : 18'(frw + 36'(osfc_pkg::FreqBase));
  // estimate row finished on odd steps 11, 13, 15, 17
  assign row = step_q[2:1] - 2'd1;

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
      out_valid_o <= 1'b0;
      fb_q <= '0; obu_q <= '0; obl_q <= '0;
      refp_q <= '0; refa_q <= '0; ascl_q <= '0; pscl_q <= '0;
      dt_q <= osfc_pkg::TimeStepReset;
      for (int i = 0; i < 4; i++) est_q[i] <= '0;
      for (int i = 0; i < 4; i++) pred_q[i] <= '0;
      acnt_q <= '0; pcnt_q <= '0;
      acc_q <= '0; prod_q <= '0;
      u_q <= '0; mx_q <= '0; mt_q <= '0;
      ex_q <= '0; et_q <= '0;
      motor_on_o <= 1'b0; direction_o <= 1'b0;
      step_frequency_o <= '0; control_effort_o <= '0;
      est_position_o <= '0; est_velocity_o <= '0;
      est_angle_o <= '0; est_angle_rate_o <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          osfc_pkg::RegFbGains: fb_q <= cfg_data_i;
          osfc_pkg::RegObsUpper: obu_q <= cfg_data_i;
          osfc_pkg::RegObsLower: obl_q <= cfg_data_i;
          osfc_pkg::RegRefPos: refp_q <= cfg_data_i[31:0];
          osfc_pkg::RegRefAngle: refa_q <= cfg_data_i[31:0];
          osfc_pkg::RegAngleScale: ascl_q <= cfg_data_i[31:0];
          osfc_pkg::RegPosScale: pscl_q <= cfg_data_i[31:0];
          osfc_pkg::RegTimeStep: dt_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            acnt_q <= angle_count_i;
            pcnt_q <= position_count_i;
            if (enable_i) begin
              state_q <= StRun;
              step_q <= '0;
              acc_q <= '0;
            end else begin
              for (int i = 0; i < 4; i++) est_q[i] <= '0;
              motor_on_o <= 1'b0; direction_o <= 1'b0;
              step_frequency_o <= '0; control_effort_o <= '0;
              est_position_o <= '0; est_velocity_o <= '0;
              est_angle_o <= '0; est_angle_rate_o <= '0;
              out_valid_o <= 1'b1;
              state_q <= StOut;
            end
          end
        end
        StRun: begin
          prod_q <= osfc_pkg::smul(ma, mb);
          // consume the product from the previous step
          if (step_q >= 5'd1 && step_q <= 5'd4) acc_q <= acc_q + prod_q;
          if (step_q == 5'd5) begin
            if (us > osfc_pkg::EffortLimit) u_q <= 32'(osfc_pkg::EffortLimit);
            else if (us < -osfc_pkg::EffortLimit) u_q <= 32'(-osfc_pkg::EffortLimit);
            else u_q <= us[31:0];
            mt_q <= osfc_pkg::sat32(prod_q >>> (32 - osfc_pkg::FracBits));
          end
          if (step_q == 5'd6) mx_q <= osfc_pkg::sat32(prod_q >>> (32 - osfc_pkg::FracBits));
          if (step_q == 5'd7)
            pred_q[0] <= osfc_pkg::sat32(66'(est_q[0]) + (prod_q >>> 16));
          if (step_q == 5'd8) begin
            pred_q[1] <= osfc_pkg::sat32(66'(est_q[1]) + (prod_q >>> 16));
            ex_q <= 33'(mx_q) - 33'(pred_q[0]);
          end
          if (step_q == 5'd9) begin
            pred_q[2] <= osfc_pkg::sat32(66'(est_q[2]) + (prod_q >>> 16));
            pred_q[3] <= est_q[3];
            et_q <= 33'(mt_q) - 33'(osfc_pkg::sat32(66'(est_q[2]) + (prod_q >>> 16)));
          end
          // correction: even steps start a row sum, odd steps finish it
          if (step_q >= 5'd10 && step_q <= 5'd17) begin
            if (step_q[0] == 1'b0) acc_q <= prod_q;
            else est_q[row] <= osfc_pkg::sat32(
                66'(pred_q[row]) + ((acc_q + prod_q) >>> 8));
          end
          if (step_q == 5'd17) begin
            state_q <= StOut;
            step_q <= '0;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        StOut: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            control_effort_o <= u_q[27:0];
            est_position_o <= est_q[0]; est_velocity_o <= est_q[1];
            est_angle_o <= est_q[2]; est_angle_rate_o <= est_q[3];
            if (mag > osfc_pkg::Deadband) begin
              motor_on_o <= 1'b1;
              direction_o <= ~u_q[31];
              step_frequency_o <= fr;
            end else begin
              motor_on_o <= 1'b0; direction_o <= 1'b0; step_frequency_o <= '0;
            end
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
